/* rtl/core/glrl_pkg.sv */
// ----------------------------------------------------------------------------
// glrl_pkg
// Shared types and constants of the gain schedule rate limiter.
// ----------------------------------------------------------------------------
package glrl_pkg;

    localparam logic [1:0] ST_FIXED   = 2'd0;
    localparam logic [1:0] ST_STALE   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_VALID   = 2'd3;

    localparam logic [2:0] CFG_SCHED_EN    = 3'd0;
    localparam logic [2:0] CFG_FIXED_GAIN  = 3'd1;
    localparam logic [2:0] CFG_GAIN_MIN    = 3'd2;
    localparam logic [2:0] CFG_GAIN_MAX    = 3'd3;
    localparam logic [2:0] CFG_RATE_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT     = 3'd5;
    localparam logic [2:0] CFG_POINT_COUNT = 3'd6;

    localparam logic [31:0] US_PER_S   = 32'd1000000;
    localparam logic [15:0] DT_MAX_US  = 16'd50000;
    localparam logic [31:0] GAIN_RESET = 32'd65536;
    localparam logic [30:0] TMO_RESET  = 31'd100;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/core/glrl_div.sv */
// ----------------------------------------------------------------------------
// glrl_div
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
// ----------------------------------------------------------------------------
module glrl_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  glrl_pkg::div_req_t  req,
    output glrl_pkg::div_rsp_t  rsp
);

    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] rem_sh;
    logic [32:0] sub;
    logic        ge;

    always_comb begin
        rem_sh = {rem_reg, dvd_reg[63]};
        sub    = rem_sh - {1'b0, dsr_reg};
        ge     = rem_sh >= {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                dvd_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? sub[31:0] : rem_sh[31:0];
                dvd_reg <= {dvd_reg[62:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

/* rtl/core/gain_schedule_rate_limiter.sv */
// ----------------------------------------------------------------------------
// gain_schedule_rate_limiter
// Table-scheduled gain with slew and range limits, Q16.16, one shared
// multiplier and one shared serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_valid / s_ready    action, times, dt, posture, breakpoint
//  m_*      out  m_valid / m_ready    accepted, model_status, gain, gain_rate
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Write item: straight from idle to the finish state. Step item: at most a
//  breakpoint scan and one run of the serial divider each for the interpolation,
//  the slew step and the rate, each run after a multiply and a divider start.
//  s_ready is high only in idle; one finished item may wait in the output
//  register while the next is accepted.
//  Synchronous active-low reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module gain_schedule_rate_limiter #(
    parameter int MAX_POINTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [31:0]        s_now_ms,
    input  logic [15:0]        s_dt_us,
    input  logic               s_posture_valid,
    input  logic signed [31:0] s_posture_position,
    input  logic [31:0]        s_posture_time_ms,
    input  logic [3:0]         s_point_slot,
    input  logic signed [31:0] s_point_position,
    input  logic [31:0]        s_point_gain,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic [1:0]         m_model_status,
    output logic [31:0]        m_gain,
    output logic signed [31:0] m_gain_rate,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK_LAST, S_CHK_FIRST, S_SCAN, S_MUL, S_DIVGO, S_DIVW,
        S_LIMIT, S_CLAMP, S_FIN
    } state_t;

    typedef enum logic [1:0] {PH_INTERP, PH_STEP, PH_RATE} phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic        sched_reg;
    logic [31:0] fixed_gain_reg;
    logic [31:0] gain_min_reg;
    logic [31:0] gain_max_reg;
    logic [31:0] rate_limit_reg;
    logic [30:0] timeout_reg;
    logic [4:0]  point_count_reg;
    logic [31:0] cur_gain_reg;

    logic signed [31:0] pos_mem  [MAX_POINTS];
    logic [31:0]        gain_mem [MAX_POINTS];
    logic signed [31:0] rd_pos_reg;
    logic [31:0]        rd_gain_reg;
    logic [AW-1:0]      rd_addr;

    logic signed [31:0] pos_reg;
    logic               stale_reg;
    logic [15:0]        dt_reg;
    logic [1:0]         status_reg;
    logic [31:0]        target_reg;
    logic [AW-1:0]      idx_reg;
    logic signed [31:0] prev_pos_reg;
    logic [31:0]        prev_gain_reg;
    logic               down_reg;
    logic [31:0]        mul_a_reg;
    logic [31:0]        mul_b_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        dsr_reg;
    logic [31:0]        step_reg;
    logic signed [33:0] v_reg;
    logic [31:0]        new_gain_reg;
    logic               neg_reg;

    logic        res_acc_reg;
    logic [1:0]  res_status_reg;
    logic [31:0] res_gain_reg;
    logic [31:0] res_rate_reg;

    logic        m_valid_reg;
    logic        m_accepted_reg;
    logic [1:0]  m_status_reg;
    logic [31:0] m_gain_reg;
    logic [31:0] m_rate_reg;

    glrl_pkg::div_req_t div_req;
    glrl_pkg::div_rsp_t div_rsp;

    logic [NW-1:0]      n_eff;
    logic               in_acc;
    logic               dt_bad;
    logic               slot_ok;
    logic signed [32:0] den;
    logic signed [32:0] num;
    logic [31:0]        gdiff;
    logic signed [33:0] lim_lo;
    logic signed [33:0] lim_hi;
    logic signed [33:0] lim_v;
    logic signed [33:0] cl1;
    logic signed [33:0] cl2;
    logic signed [32:0] delta;
    logic [31:0]        rate_sat;

    glrl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_req.start    = (state_reg == S_DIVGO);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = dsr_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;

    always_comb begin
        if (32'(point_count_reg) > 32'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(point_count_reg);
        end
        dt_bad  = (s_dt_us == 16'd0) || (s_dt_us > glrl_pkg::DT_MAX_US);
        slot_ok = {28'd0, s_point_slot} < 32'(MAX_POINTS);
        case (state_reg)
            S_IDLE:      rd_addr = AW'(n_eff - NW'(1));
            S_CHK_LAST:  rd_addr = '0;
            S_CHK_FIRST: rd_addr = AW'(1);
            default:     rd_addr = idx_reg + AW'(1);
        endcase
        den   = {rd_pos_reg[31], rd_pos_reg} - {prev_pos_reg[31], prev_pos_reg};
        num   = {pos_reg[31], pos_reg} - {prev_pos_reg[31], prev_pos_reg};
        gdiff = (rd_gain_reg >= prev_gain_reg) ? (rd_gain_reg - prev_gain_reg)
                                               : (prev_gain_reg - rd_gain_reg);
        lim_lo = {2'b00, cur_gain_reg} - {2'b00, step_reg};
        lim_hi = {2'b00, cur_gain_reg} + {2'b00, step_reg};
        if ($signed({2'b00, target_reg}) < lim_lo) begin
            lim_v = lim_lo;
        end else if ($signed({2'b00, target_reg}) > lim_hi) begin
            lim_v = lim_hi;
        end else begin
            lim_v = {2'b00, target_reg};
        end
        cl1 = (v_reg < {2'b00, gain_min_reg}) ? {2'b00, gain_min_reg} : v_reg;
        cl2 = (cl1 > {2'b00, gain_max_reg}) ? {2'b00, gain_max_reg} : cl1;
        delta = {1'b0, cl2[31:0]} - {1'b0, cur_gain_reg};
        if (neg_reg) begin
            rate_sat = (div_rsp.quotient > 64'h8000_0000) ? 32'h8000_0000
                                                          : 32'(-div_rsp.quotient);
        end else begin
            rate_sat = (div_rsp.quotient > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                          : div_rsp.quotient[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_action && slot_ok) begin
            pos_mem[AW'(s_point_slot)]  <= s_point_position;
            gain_mem[AW'(s_point_slot)] <= s_point_gain;
        end
        rd_pos_reg  <= pos_mem[rd_addr];
        rd_gain_reg <= gain_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_STEP;
            sched_reg       <= 1'b0;
            fixed_gain_reg  <= glrl_pkg::GAIN_RESET;
            gain_min_reg    <= glrl_pkg::GAIN_RESET;
            gain_max_reg    <= glrl_pkg::GAIN_RESET;
            rate_limit_reg  <= glrl_pkg::GAIN_RESET;
            timeout_reg     <= glrl_pkg::TMO_RESET;
            point_count_reg <= '0;
            cur_gain_reg    <= glrl_pkg::GAIN_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    glrl_pkg::CFG_SCHED_EN:    sched_reg <= cfg_data[0];
                    glrl_pkg::CFG_FIXED_GAIN: begin
                        fixed_gain_reg <= cfg_data;
                        cur_gain_reg   <= cfg_data;
                    end
                    glrl_pkg::CFG_GAIN_MIN:    gain_min_reg    <= cfg_data;
                    glrl_pkg::CFG_GAIN_MAX:    gain_max_reg    <= cfg_data;
                    glrl_pkg::CFG_RATE_LIMIT:  rate_limit_reg  <= cfg_data;
                    glrl_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data[30:0];
                    glrl_pkg::CFG_POINT_COUNT: point_count_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        pos_reg    <= s_posture_position;
                        dt_reg     <= s_dt_us;
                        stale_reg  <= (s_now_ms - s_posture_time_ms) > {1'b0, timeout_reg};
                        target_reg <= fixed_gain_reg;
                        mul_a_reg  <= rate_limit_reg;
                        mul_b_reg  <= {16'd0, s_dt_us};
                        dsr_reg    <= glrl_pkg::US_PER_S;
                        phase_reg  <= PH_STEP;
                        if (s_action) begin
                            res_acc_reg    <= 1'b1;
                            res_status_reg <= glrl_pkg::ST_FIXED;
                            res_gain_reg   <= cur_gain_reg;
                            res_rate_reg   <= '0;
                            state_reg      <= S_FIN;
                        end else if (dt_bad) begin
                            res_acc_reg    <= 1'b0;
                            res_status_reg <= glrl_pkg::ST_FIXED;
                            res_gain_reg   <= '0;
                            res_rate_reg   <= '0;
                            state_reg      <= S_FIN;
                        end else if (!sched_reg) begin
                            status_reg <= glrl_pkg::ST_FIXED;
                            state_reg  <= S_MUL;
                        end else if (!s_posture_valid) begin
                            status_reg <= glrl_pkg::ST_STALE;
                            state_reg  <= S_MUL;
                        end else if (n_eff < NW'(2)) begin
                            status_reg <= glrl_pkg::ST_INVALID;
                            state_reg  <= S_MUL;
                        end else begin
                            state_reg <= S_CHK_LAST;
                        end
                    end
                end
                S_CHK_LAST: begin
                    if (pos_reg > rd_pos_reg) begin
                        status_reg <= glrl_pkg::ST_INVALID;
                        state_reg  <= S_MUL;
                    end else begin
                        state_reg <= S_CHK_FIRST;
                    end
                end
                S_CHK_FIRST: begin
                    prev_pos_reg  <= rd_pos_reg;
                    prev_gain_reg <= rd_gain_reg;
                    idx_reg       <= AW'(1);
                    if (pos_reg < rd_pos_reg) begin
                        status_reg <= glrl_pkg::ST_INVALID;
                        state_reg  <= S_MUL;
                    end else if (stale_reg) begin
                        status_reg <= glrl_pkg::ST_STALE;
                        state_reg  <= S_MUL;
                    end else begin
                        status_reg <= glrl_pkg::ST_VALID;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (pos_reg <= rd_pos_reg) begin
                        if (den <= 33'sd0) begin
                            res_acc_reg    <= 1'b0;
                            res_status_reg <= glrl_pkg::ST_FIXED;
                            res_gain_reg   <= '0;
                            res_rate_reg   <= '0;
                            state_reg      <= S_FIN;
                        end else begin
                            mul_a_reg <= num[32] ? 32'd0 : num[31:0];
                            mul_b_reg <= gdiff;
                            dsr_reg   <= den[31:0];
                            down_reg  <= rd_gain_reg < prev_gain_reg;
                            phase_reg <= PH_INTERP;
                            state_reg <= S_MUL;
                        end
                    end else begin
                        prev_pos_reg  <= rd_pos_reg;
                        prev_gain_reg <= rd_gain_reg;
                        idx_reg       <= idx_reg + AW'(1);
                    end
                end
                S_MUL: begin
                    prod_reg  <= 64'(mul_a_reg) * 64'(mul_b_reg);
                    state_reg <= S_DIVGO;
                end
                S_DIVGO: begin
                    state_reg <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        case (phase_reg)
                            PH_INTERP: begin
                                target_reg <= down_reg
                                    ? prev_gain_reg - div_rsp.quotient[31:0]
                                    : prev_gain_reg + div_rsp.quotient[31:0];
                                mul_a_reg <= rate_limit_reg;
                                mul_b_reg <= {16'd0, dt_reg};
                                dsr_reg   <= glrl_pkg::US_PER_S;
                                phase_reg <= PH_STEP;
                                state_reg <= S_MUL;
                            end
                            PH_STEP: begin
                                step_reg  <= div_rsp.quotient[31:0];
                                state_reg <= S_LIMIT;
                            end
                            default: begin
                                res_acc_reg    <= 1'b1;
                                res_status_reg <= status_reg;
                                res_gain_reg   <= new_gain_reg;
                                res_rate_reg   <= rate_sat;
                                cur_gain_reg   <= new_gain_reg;
                                state_reg      <= S_FIN;
                            end
                        endcase
                    end
                end
                S_LIMIT: begin
                    v_reg     <= lim_v;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    new_gain_reg <= cl2[31:0];
                    neg_reg      <= delta[32];
                    mul_a_reg    <= delta[32] ? 32'(-delta) : delta[31:0];
                    mul_b_reg    <= glrl_pkg::US_PER_S;
                    dsr_reg      <= {16'd0, dt_reg};
                    phase_reg    <= PH_RATE;
                    if (cl2[31:0] == 32'd0) begin
                        res_acc_reg    <= 1'b0;
                        res_status_reg <= glrl_pkg::ST_FIXED;
                        res_gain_reg   <= '0;
                        res_rate_reg   <= '0;
                        state_reg      <= S_FIN;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_accepted_reg <= res_acc_reg;
                        m_status_reg   <= res_status_reg;
                        m_gain_reg     <= res_gain_reg;
                        m_rate_reg     <= res_rate_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_accepted     = m_accepted_reg;
    assign m_model_status = m_status_reg;
    assign m_gain         = m_gain_reg;
    assign m_gain_rate    = m_rate_reg;

endmodule

/* tb/tb_gain_schedule_rate_limiter.sv */
// ----------------------------------------------------------------------------
// tb_gain_schedule_rate_limiter
// Self-checking bench: directed corner items, then randomized phases under
// changing register settings, with random source gaps and sink stalls.
// Every result is compared against an in-bench predictor of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gain_schedule_rate_limiter;

    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int   WDOG_LIMIT = 20000;

    typedef struct {
        logic               action;
        logic [31:0]        now_ms;
        logic [15:0]        dt_us;
        logic               posture_valid;
        logic signed [31:0] posture_position;
        logic [31:0]        posture_time_ms;
        logic [3:0]         point_slot;
        logic signed [31:0] point_position;
        logic [31:0]        point_gain;
    } item_t;

    typedef struct {
        logic        accepted;
        logic [1:0]  model_status;
        logic [31:0] gain;
        logic [31:0] gain_rate;
    } result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = 1'b0;
    logic [31:0]        s_now_ms = '0;
    logic [15:0]        s_dt_us = '0;
    logic               s_posture_valid = 1'b0;
    logic signed [31:0] s_posture_position = '0;
    logic [31:0]        s_posture_time_ms = '0;
    logic [3:0]         s_point_slot = '0;
    logic signed [31:0] s_point_position = '0;
    logic [31:0]        s_point_gain = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_accepted;
    logic [1:0]         m_model_status;
    logic [31:0]        m_gain;
    logic signed [31:0] m_gain_rate;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    always #4 aclk = ~aclk;

    gain_schedule_rate_limiter dut (.*);

    // predictor state
    logic        sched_en   = 1'b0;
    logic [31:0] fixed_gain = glrl_pkg::GAIN_RESET;
    logic [31:0] gain_lo    = glrl_pkg::GAIN_RESET;
    logic [31:0] gain_hi    = glrl_pkg::GAIN_RESET;
    logic [31:0] rate_lim   = glrl_pkg::GAIN_RESET;
    logic [30:0] timeout_ms = glrl_pkg::TMO_RESET;
    logic [4:0]  pt_count   = '0;
    logic [31:0] cur_gain   = glrl_pkg::GAIN_RESET;
    longint      tbl_pos [16];
    logic [31:0] tbl_gain [16];

    item_t   pending_items [$];
    result_t expected_results [$];
    int      n_err = 0, n_steps = 0, n_writes = 0, n_rejects = 0, n_results = 0;
    int      status_seen [4] = '{0, 0, 0, 0};
    longint  bp_base, bp_span;

    function automatic result_t predict_gain(input item_t it);
        result_t     r;
        logic [1:0]  st;
        longint      tgt, old, lim, v, rate, lo, den, num, pos, gmin, gmax;
        logic [63:0] off;
        logic [31:0] age, gl, gh, dg;
        int          n;
        bit          found;
        r = '{1'b0, glrl_pkg::ST_FIXED, 32'd0, 32'd0};
        if (it.action == ACT_WRITE) begin
            tbl_pos[it.point_slot] = longint'(it.point_position);
            tbl_gain[it.point_slot] = it.point_gain;
            r.accepted = 1'b1;
            r.gain = cur_gain;
            return r;
        end
        if (it.dt_us == 16'd0 || it.dt_us > glrl_pkg::DT_MAX_US) return r;
        st = glrl_pkg::ST_FIXED;
        tgt = longint'({32'd0, fixed_gain});
        if (sched_en) begin
            st = glrl_pkg::ST_STALE;
            if (it.posture_valid) begin
                n = (pt_count > 16) ? 16 : int'(pt_count);
                pos = longint'(it.posture_position);
                if (n < 2 || pos < tbl_pos[0] || pos > tbl_pos[n-1]) begin
                    st = glrl_pkg::ST_INVALID;
                end else begin
                    age = it.now_ms - it.posture_time_ms;
                    if (age <= {1'b0, timeout_ms}) begin
                        st = glrl_pkg::ST_VALID;
                        found = 0;
                        for (int i = 1; i < n; i++) begin
                            if (!found && pos <= tbl_pos[i]) begin
                                found = 1;
                                lo = tbl_pos[i-1];
                                den = tbl_pos[i] - lo;
                                if (den <= 0) return r;
                                num = pos - lo;
                                if (num < 0) num = 0;
                                gl = tbl_gain[i-1];
                                gh = tbl_gain[i];
                                dg = (gh >= gl) ? gh - gl : gl - gh;
                                off = 64'(num) * {32'd0, dg} / 64'(den);
                                if (gh >= gl) tgt = longint'({32'd0, gl}) + longint'(off);
                                else tgt = longint'({32'd0, gl}) - longint'(off);
                            end
                        end
                    end
                end
            end
        end
        old = longint'({32'd0, cur_gain});
        lim = longint'({32'd0, rate_lim} * {48'd0, it.dt_us} / 64'd1000000);
        gmin = longint'({32'd0, gain_lo});
        gmax = longint'({32'd0, gain_hi});
        v = tgt;
        if (v < old - lim) v = old - lim;
        if (v > old + lim) v = old + lim;
        if (v < gmin) v = gmin;
        if (v > gmax) v = gmax;
        if (v <= 0) return r;
        rate = (v - old) * 64'sd1000000 / longint'({48'd0, it.dt_us});
        if (rate > 64'sd2147483647) rate = 64'sd2147483647;
        if (rate < -64'sd2147483648) rate = -64'sd2147483648;
        cur_gain = v[31:0];
        r.accepted = 1'b1;
        r.model_status = st;
        r.gain = v[31:0];
        r.gain_rate = rate[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string fld, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got %h want %h", n_results, fld, got, want);
        n_err++;
    endtask

    // source side
    item_t s_item;
    int    s_gap = 0;
    bit    s_burst = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_gain(s_item));
                if (s_item.action == ACT_WRITE) n_writes++;
                else n_steps++;
                if ($urandom_range(0, 63) == 0) s_burst = !s_burst;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_item = pending_items.pop_front();
                    s_action <= s_item.action;
                    s_now_ms <= s_item.now_ms;
                    s_dt_us <= s_item.dt_us;
                    s_posture_valid <= s_item.posture_valid;
                    s_posture_position <= s_item.posture_position;
                    s_posture_time_ms <= s_item.posture_time_ms;
                    s_point_slot <= s_item.point_slot;
                    s_point_position <= s_item.point_position;
                    s_point_gain <= s_item.point_gain;
                    s_valid <= 1'b1;
                    s_gap = s_burst ? 0 : $urandom_range(0, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side
    int m_wait = 0;
    bit m_burst = 0;
    result_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("unexpected result %0d", n_results);
                    n_err++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_accepted !== want.accepted)
                        report_mismatch("accepted", 32'(m_accepted), 32'(want.accepted));
                    if (m_model_status !== want.model_status)
                        report_mismatch("model_status", 32'(m_model_status),
                                        32'(want.model_status));
                    if (m_gain !== want.gain) report_mismatch("gain", m_gain, want.gain);
                    if (m_gain_rate !== want.gain_rate)
                        report_mismatch("gain_rate", m_gain_rate, want.gain_rate);
                    if (!want.accepted) n_rejects++;
                    else status_seen[want.model_status]++;
                end
                if ($urandom_range(0, 63) == 0) m_burst = !m_burst;
                m_wait = m_burst ? 0 : $urandom_range(0, 19);
            end else if (m_wait > 0) begin
                m_wait--;
            end
            m_ready <= (m_wait == 0);
        end
    end

    // watchdog
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_LIMIT) begin
            $display("no progress for %0d cycles", WDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            glrl_pkg::CFG_SCHED_EN:    sched_en = d[0];
            glrl_pkg::CFG_FIXED_GAIN:  begin fixed_gain = d; cur_gain = d; end
            glrl_pkg::CFG_GAIN_MIN:    gain_lo = d;
            glrl_pkg::CFG_GAIN_MAX:    gain_hi = d;
            glrl_pkg::CFG_RATE_LIMIT:  rate_lim = d;
            glrl_pkg::CFG_TIMEOUT:     timeout_ms = d[30:0];
            glrl_pkg::CFG_POINT_COUNT: pt_count = d[4:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    function automatic item_t mk_step(input logic [31:0] now, input logic [15:0] dt,
                                      input logic pv, input longint pp,
                                      input logic [31:0] pt);
        item_t it;
        it = '{ACT_STEP, now, dt, pv, pp[31:0], pt, 4'($urandom), $urandom, $urandom};
        return it;
    endfunction

    function automatic item_t mk_write(input logic [3:0] slot, input longint pp,
                                       input logic [31:0] g);
        item_t it;
        it = '{ACT_WRITE, $urandom, 16'($urandom), 1'($urandom), $urandom, $urandom,
               slot, pp[31:0], g};
        return it;
    endfunction

    function automatic logic [31:0] pick_gain();
        if (gain_lo <= gain_hi && $urandom_range(0, 4) != 0)
            return $urandom_range(gain_lo, gain_hi);
        return $urandom;
    endfunction

    function automatic longint ordered_pos(input int slot);
        return bp_base + slot * bp_span + $urandom_range(0, int'(bp_span / 2));
    endfunction

    function automatic item_t rand_item();
        logic [31:0] now, age;
        logic [15:0] dt;
        longint      pp;
        int          k;
        k = $urandom_range(0, 99);
        if (k < 12) return mk_write(4'($urandom), ordered_pos(0) + 0, pick_gain()) ;
        if (k < 15) return mk_write(4'($urandom), longint'($signed($urandom)), $urandom);
        k = $urandom_range(0, 99);
        if (k < 8) dt = 16'd0 + (($urandom_range(0, 1) == 0) ? 16'd0 :
                                 16'($urandom_range(50001, 65535)));
        else if (k < 30) dt = 16'($urandom_range(1, 1000));
        else dt = 16'($urandom_range(1, 50000));
        now = $urandom;
        k = $urandom_range(0, 99);
        if (k < 75) age = $urandom_range(0, timeout_ms);
        else if (k < 90) age = {1'b0, timeout_ms} + $urandom_range(1, 1000);
        else age = $urandom;
        if ($urandom_range(0, 9) == 0) pp = longint'($signed($urandom));
        else pp = bp_base - bp_span + $urandom_range(0, int'(17 * bp_span));
        return mk_step(now, dt, $urandom_range(0, 9) != 0, pp, now - age);
    endfunction

    task automatic load_table();
        for (int i = 0; i < 16; i++)
            pending_items.push_back(mk_write(4'(i), ordered_pos(i), pick_gain()));
    endtask

    item_t tmp;
    logic [31:0] now0, gmin_r;

    initial begin
        bp_span = longint'(1) << 20;
        bp_base = -8 * bp_span;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // scheduling off, reset settings: table fill and interval edges
        load_table();
        pending_items.push_back(mk_step($urandom, 16'd0, 1'b1, 0, 0));
        pending_items.push_back(mk_step($urandom, 16'd1, 1'b1, 0, 0));
        pending_items.push_back(mk_step($urandom, glrl_pkg::DT_MAX_US, 1'b1, 0, 0));
        pending_items.push_back(mk_step($urandom, glrl_pkg::DT_MAX_US + 16'd1, 1'b1, 0, 0));
        pending_items.push_back(mk_step($urandom, 16'hFFFF, 1'b1, 0, 0));
        wait_idle();

        cfg_write(glrl_pkg::CFG_SCHED_EN, 32'd1);
        cfg_write(glrl_pkg::CFG_FIXED_GAIN, 32'h0002_0000);
        cfg_write(glrl_pkg::CFG_GAIN_MIN, 32'd1);
        cfg_write(glrl_pkg::CFG_GAIN_MAX, 32'hFFFF_FFFF);
        cfg_write(glrl_pkg::CFG_RATE_LIMIT, 32'hFFFF_FFFF);
        cfg_write(glrl_pkg::CFG_TIMEOUT, 32'd100);
        cfg_write(glrl_pkg::CFG_POINT_COUNT, 32'd16);
        wait_idle();
        now0 = 32'd50;
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b0, tbl_pos[3], now0));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[0] - 1, now0));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[15] + 1, now0));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[0], now0));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[15], now0));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1,
                                        (tbl_pos[6] + tbl_pos[7]) / 2, now0));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[4], now0 - 100));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[4], now0 - 101));
        pending_items.push_back(mk_step(32'd10, 16'd1000, 1'b1, tbl_pos[9], 32'hFFFF_FFF0));
        // zero-width segment between the first two breakpoints
        pending_items.push_back(mk_write(4'd1, tbl_pos[0], tbl_gain[1]));
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[0], now0));
        pending_items.push_back(mk_write(4'd1, ordered_pos(1), tbl_gain[1]));
        wait_idle();
        cfg_write(glrl_pkg::CFG_POINT_COUNT, 32'd1);
        pending_items.push_back(mk_step(now0, 16'd1000, 1'b1, tbl_pos[0], now0));
        wait_idle();
        cfg_write(glrl_pkg::CFG_POINT_COUNT, 32'd20);
        pending_items.push_back(mk_step(now0, 16'd2000, 1'b1, tbl_pos[12] + 5, now0));
        wait_idle();
        cfg_write(glrl_pkg::CFG_GAIN_MIN, 32'h0003_0000);
        cfg_write(glrl_pkg::CFG_GAIN_MAX, 32'h0002_0000);
        pending_items.push_back(mk_step(now0, 16'd3000, 1'b1, tbl_pos[2], now0));
        wait_idle();

        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 0) begin
                cfg_write(glrl_pkg::CFG_SCHED_EN, 32'd1);
                cfg_write(glrl_pkg::CFG_FIXED_GAIN, 32'hFFFF_FFFF);
                cfg_write(glrl_pkg::CFG_GAIN_MIN, 32'd1);
                cfg_write(glrl_pkg::CFG_GAIN_MAX, 32'hFFFF_FFFF);
                cfg_write(glrl_pkg::CFG_RATE_LIMIT, 32'hFFFF_FFFF);
                cfg_write(glrl_pkg::CFG_TIMEOUT, 32'h7FFF_FFFF);
                cfg_write(glrl_pkg::CFG_POINT_COUNT, 32'd16);
            end else if (ph == 1) begin
                cfg_write(glrl_pkg::CFG_FIXED_GAIN, 32'd1);
                cfg_write(glrl_pkg::CFG_GAIN_MIN, 32'd1);
                cfg_write(glrl_pkg::CFG_GAIN_MAX, 32'd1);
                cfg_write(glrl_pkg::CFG_RATE_LIMIT, 32'd1);
                cfg_write(glrl_pkg::CFG_TIMEOUT, 32'd1);
                cfg_write(glrl_pkg::CFG_POINT_COUNT, 32'd2);
            end else begin
                gmin_r = $urandom_range(1, 32'h0010_0000);
                cfg_write(glrl_pkg::CFG_SCHED_EN, 32'($urandom_range(0, 4) != 0));
                cfg_write(glrl_pkg::CFG_FIXED_GAIN, $urandom_range(1, 32'h0100_0000));
                cfg_write(glrl_pkg::CFG_GAIN_MIN, gmin_r);
                cfg_write(glrl_pkg::CFG_GAIN_MAX, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(1, gmin_r) : gmin_r + $urandom_range(0, 32'h0100_0000));
                cfg_write(glrl_pkg::CFG_RATE_LIMIT, ($urandom_range(0, 1) == 0) ? $urandom :
                          $urandom_range(1, 32'h0100_0000));
                cfg_write(glrl_pkg::CFG_TIMEOUT, ($urandom_range(0, 3) == 0) ?
                          {1'b0, 31'($urandom)} : $urandom_range(1, 500));
                cfg_write(glrl_pkg::CFG_POINT_COUNT, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(17, 31) : $urandom_range(0, 16));
            end
            load_table();
            repeat (112) begin
                tmp = rand_item();
                pending_items.push_back(tmp);
            end
            wait_idle();
        end

        repeat (300) @(negedge aclk);
        $display("%0d steps, %0d breakpoint writes, %0d rejected", n_steps, n_writes,
                 n_rejects);
        $display("status counts fixed/stale/invalid/valid: %0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_err == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/glrl_pkg.sv
rtl/core/glrl_div.sv
rtl/core/gain_schedule_rate_limiter.sv
tb/tb_gain_schedule_rate_limiter.sv
